### src/m3irs_pkg.sv
// ============================================================================
// m3irs_pkg - shared types and constants of the median-3 IR range sampler
// Field widths, block length, divider sizing and configuration register codes.
// ============================================================================
package m3irs_pkg;

    localparam int BLOCK_LEN = 64;
    localparam int FILL_W    = $clog2(BLOCK_LEN + 1);

    localparam int SAMPLE_W  = 12;
    localparam int DIST_W    = 16;
    localparam int SLOT_W    = 6;
    localparam int SCALE_W   = 20;

    localparam int DIV_STEPS = SCALE_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_NEAR_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_DISTANCE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_NUMERATOR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_OFFSET   = 2'd3;

    localparam logic [SAMPLE_W-1:0] RST_NEAR_THRESHOLD  = 12'd494;
    localparam logic [DIST_W-1:0]   RST_FAR_DISTANCE    = 16'd799;
    localparam logic [SCALE_W-1:0]  RST_SCALE_NUMERATOR = 20'd268130;
    localparam logic [SAMPLE_W-1:0] RST_SAMPLE_OFFSET   = 12'd159;

endpackage

### src/m3irs_in_if.sv
// ============================================================================
// m3irs_in_if - sample channel
// Valid/ready channel that carries one sample or release request per transfer.
// ============================================================================
interface m3irs_in_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic [m3irs_pkg::SAMPLE_W-1:0]    sample;

    modport source (output valid, output req_type, output sample, input ready);
    modport sink   (input valid, input req_type, input sample, output ready);
endinterface

### src/m3irs_out_if.sv
// ============================================================================
// m3irs_out_if - distance channel
// Valid/ready channel that carries one converted distance per transfer.
// ============================================================================
interface m3irs_out_if;
    logic                              valid;
    logic                              ready;
    logic [m3irs_pkg::DIST_W-1:0]      distance;
    logic [m3irs_pkg::SLOT_W-1:0]      slot;
    logic                              last_of_block;

    modport source (output valid, output distance, output slot, output last_of_block,
                    input ready);
    modport sink   (input valid, input distance, input slot, input last_of_block,
                    output ready);
endinterface

### src/median3_ir_range_sampler.sv
// ============================================================================
// median3_ir_range_sampler - median-3 filter with reciprocal distance mapping
// Keeps a two-sample history, takes the median of three and converts it to a
// distance with a bit-serial restoring divider.
// ============================================================================
// A sample that yields a result is taken with its median formed, the
// thresholds are checked, the restoring divider runs 20 steps (one quotient
// bit per cycle, set by the 20-bit scale numerator), the quotient is
// saturated and the output register loaded. A far-distance fallback skips
// the divider and the saturation. A release, or a sample after the block is
// full, leaves the block idle and yields no result. The output register
// holds a finished distance while the next sample is taken, so a slow
// consumer only stalls the block once a second result is ready.
// Configuration writes are meant for idle time.
module median3_ir_range_sampler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    m3irs_in_if.sink                           i_smp,
    m3irs_out_if.source                        o_res,
    input  logic                               i_cfg_we,
    input  logic [m3irs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [m3irs_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam int SW = m3irs_pkg::SAMPLE_W;
    localparam int QW = m3irs_pkg::SCALE_W;
    localparam int DW = m3irs_pkg::DIST_W;
    localparam int FW = m3irs_pkg::FILL_W;
    localparam logic [FW-1:0] BLOCK_END = FW'(m3irs_pkg::BLOCK_LEN);
    localparam logic [m3irs_pkg::CNT_W-1:0] LAST_STEP =
        m3irs_pkg::CNT_W'(m3irs_pkg::DIV_STEPS - 1);

    logic [1:0]               r_state;
    logic                     r_sat;

    logic [SW-1:0]            r_thr;
    logic [DW-1:0]            r_far;
    logic [QW-1:0]            r_scale;
    logic [SW-1:0]            r_off;

    logic [SW-1:0]            r_new;
    logic [SW-1:0]            r_old;
    logic [FW-1:0]            r_fill;

    logic [SW-1:0]            r_med;
    logic [m3irs_pkg::SLOT_W-1:0] r_slot;
    logic                     r_last;

    logic [SW-1:0]            r_div;
    logic [SW-1:0]            r_rem;
    logic [QW-1:0]            r_quo;
    logic [m3irs_pkg::CNT_W-1:0] r_cnt;
    logic [DW-1:0]            r_dist;

    logic                     r_ovalid;
    logic [DW-1:0]            r_odist;
    logic [m3irs_pkg::SLOT_W-1:0] r_oslot;
    logic                     r_olast;

    logic                     w_acc;
    logic [SW-1:0]            w_med;
    logic [SW:0]              w_trial;
    logic                     w_ge;
    logic                     w_oload;

    assign i_smp.ready = (r_state == ST_IDLE);
    assign w_acc       = i_smp.valid && i_smp.ready;

    // Median of the incoming sample and the two held ones
    always_comb begin
        if (i_smp.sample > r_new) begin
            if (r_new > r_old) begin
                w_med = r_new;
            end else begin
                w_med = (i_smp.sample > r_old) ? r_old : i_smp.sample;
            end
        end else begin
            if (r_old > r_new) begin
                w_med = r_new;
            end else begin
                w_med = (i_smp.sample > r_old) ? i_smp.sample : r_old;
            end
        end
    end

    // One restoring divide step: bring down the next numerator bit
    assign w_trial = {r_rem, r_quo[QW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    assign w_oload = (r_state == ST_DONE) && (!r_ovalid || o_res.ready);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= m3irs_pkg::RST_NEAR_THRESHOLD;
            r_far   <= m3irs_pkg::RST_FAR_DISTANCE;
            r_scale <= m3irs_pkg::RST_SCALE_NUMERATOR;
            r_off   <= m3irs_pkg::RST_SAMPLE_OFFSET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                m3irs_pkg::REG_NEAR_THRESHOLD:  r_thr   <= i_cfg_data[SW-1:0];
                m3irs_pkg::REG_FAR_DISTANCE:    r_far   <= i_cfg_data[DW-1:0];
                m3irs_pkg::REG_SCALE_NUMERATOR: r_scale <= i_cfg_data[QW-1:0];
                m3irs_pkg::REG_SAMPLE_OFFSET:   r_off   <= i_cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    // Control: history, fill count and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_new   <= '0;
            r_old   <= '0;
            r_fill  <= '0;
            r_cnt   <= '0;
            r_sat   <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        if (i_smp.req_type) begin
                            r_fill <= '0;
                        end else begin
                            r_old <= r_new;
                            r_new <= i_smp.sample;
                            if (r_fill < BLOCK_END) begin
                                r_fill  <= r_fill + 1'b1;
                                r_state <= ST_PREP;
                            end
                        end
                    end
                end
                ST_PREP: begin
                    r_cnt <= '0;
                    if ((r_med < r_thr) || (r_med <= r_off)) begin
                        r_sat   <= 1'b0;
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_sat   <= 1'b1;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    r_sat <= 1'b0;
                    if (w_oload && !r_sat) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath: median capture, divider, saturation
    always_ff @(posedge i_clk) begin
        if (w_acc && !i_smp.req_type) begin
            r_med  <= w_med;
            r_slot <= m3irs_pkg::SLOT_W'(r_fill);
            r_last <= (r_fill == BLOCK_END - 1'b1);
        end
        if (r_state == ST_PREP) begin
            r_dist <= r_far;
            r_quo  <= r_scale;
            r_rem  <= '0;
            r_div  <= r_med - r_off;
        end
        if (r_state == ST_DIV) begin
            r_rem <= w_ge ? SW'(w_trial - {1'b0, r_div}) : w_trial[SW-1:0];
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
        // Saturate the quotient in the cycle after the last divide step
        if (r_state == ST_DONE && r_sat) begin
            r_dist <= (|r_quo[QW-1:DW]) ? '1 : r_quo[DW-1:0];
        end
    end

    // Output register: hold a result until the sink takes the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_oload && !r_sat) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_oload && !r_sat) begin
            r_odist <= r_dist;
            r_oslot <= r_slot;
            r_olast <= r_last;
        end
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.distance      = r_odist;
    assign o_res.slot          = r_oslot;
    assign o_res.last_of_block = r_olast;

endmodule

### tb/m3irs_tb_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// m3irs_tb_pkg - verification types for the median-3 IR range sampler
// Request codes of the sample channel and the layout of one expected range.
// ============================================================================
package m3irs_tb_pkg;

    typedef enum logic {
        REQ_SAMPLE  = 1'b0,
        REQ_RELEASE = 1'b1
    } sampler_req_e;

    typedef struct packed {
        logic [m3irs_pkg::DIST_W-1:0] distance;
        logic [m3irs_pkg::SLOT_W-1:0] slot;
        logic                         last_of_block;
    } range_result_t;

endpackage

### tb/m3irs_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// m3irs_checker - range predictor and scoreboard
// Follows the configuration port and the sample channel to predict each
// distance, slot and end-of-block flag, and compares every transfer on the
// distance channel with the oldest prediction still due.
// ============================================================================
module m3irs_checker
    import m3irs_pkg::*;
    import m3irs_tb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    m3irs_in_if                  i_smp,
    m3irs_out_if                 i_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_outstanding
);

    logic [SAMPLE_W-1:0] near_thr;
    logic [DIST_W-1:0]   far_dist;
    logic [SCALE_W-1:0]  scale_num;
    logic [SAMPLE_W-1:0] smp_off;

    logic [SAMPLE_W-1:0] newest;
    logic [SAMPLE_W-1:0] older;
    int                  fill;

    range_result_t       ranges_due[$];
    int                  fail_total = 0;
    int                  due_count  = 0;

    assign o_fail_count  = fail_total;
    assign o_outstanding = due_count;

    function automatic logic [SAMPLE_W-1:0] median_of_three(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b,
        input logic [SAMPLE_W-1:0] c
    );
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c <= lo) return lo;
        if (c >= hi) return hi;
        return c;
    endfunction

    function automatic logic [DIST_W-1:0] range_of(input logic [SAMPLE_W-1:0] mid);
        logic [SCALE_W-1:0] quo;
        logic [SCALE_W-1:0] divisor;
        // below the near threshold, or a divisor of zero or less: report far
        if (mid < near_thr || mid <= smp_off) return far_dist;
        divisor = SCALE_W'(mid) - SCALE_W'(smp_off);
        quo = scale_num / divisor;
        if (quo > SCALE_W'(16'hFFFF)) return 16'hFFFF;
        return quo[DIST_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t  range check: %s", $time, msg);
        fail_total++;
    endtask

    always @(posedge i_clk) begin : track
        range_result_t       got;
        range_result_t       want;
        logic [SAMPLE_W-1:0] mid;
        if (!i_rst_n) begin
            near_thr  = RST_NEAR_THRESHOLD;
            far_dist  = RST_FAR_DISTANCE;
            scale_num = RST_SCALE_NUMERATOR;
            smp_off   = RST_SAMPLE_OFFSET;
            newest    = '0;
            older     = '0;
            fill      = 0;
            ranges_due.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.distance      = i_res.distance;
                got.slot          = i_res.slot;
                got.last_of_block = i_res.last_of_block;
                if (ranges_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected transfer distance %0d slot %0d last %0b",
                                              got.distance, got.slot, got.last_of_block));
                end else begin
                    want = ranges_due.pop_front();
                    if (got.distance !== want.distance)
                        report_mismatch($sformatf("distance got %0d want %0d (slot %0d)",
                                                  got.distance, want.distance, want.slot));
                    if (got.slot !== want.slot)
                        report_mismatch($sformatf("slot got %0d want %0d",
                                                  got.slot, want.slot));
                    if (got.last_of_block !== want.last_of_block)
                        report_mismatch($sformatf("last_of_block got %0b want %0b (slot %0d)",
                                                  got.last_of_block, want.last_of_block,
                                                  want.slot));
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_NEAR_THRESHOLD:  near_thr  = i_cfg_data[SAMPLE_W-1:0];
                    REG_FAR_DISTANCE:    far_dist  = i_cfg_data[DIST_W-1:0];
                    REG_SCALE_NUMERATOR: scale_num = i_cfg_data[SCALE_W-1:0];
                    REG_SAMPLE_OFFSET:   smp_off   = i_cfg_data[SAMPLE_W-1:0];
                    default: ;
                endcase
            end

            if (i_smp.valid && i_smp.ready) begin
                if (i_smp.req_type == REQ_RELEASE) begin
                    // restart the slot count, keep the history
                    fill = 0;
                end else begin
                    mid   = median_of_three(i_smp.sample, newest, older);
                    older = newest;
                    newest = i_smp.sample;
                    if (fill < BLOCK_LEN) begin
                        want.distance      = range_of(mid);
                        want.slot          = fill[SLOT_W-1:0];
                        fill++;
                        want.last_of_block = (fill == BLOCK_LEN);
                        ranges_due.push_back(want);
                    end
                end
            end
        end
        due_count = ranges_due.size();
    end

endmodule

### tb/median3_ir_range_sampler_test.sv
`timescale 1ns / 1ps
// ============================================================================
// median3_ir_range_sampler_test - testbench top of the median-3 range sampler
// Drives samples and releases in random bursts against a stalling consumer,
// walks the configuration through extreme and random settings between idle
// phases, and reports the checker's verdict.
// ============================================================================
module median3_ir_range_sampler_test;
    import m3irs_pkg::*;
    import m3irs_tb_pkg::*;

    localparam int  HALF_PERIOD   = 5;
    localparam int  SETTLE_CYCLES = 32;
    localparam int  HOLD_CYCLES   = 400;
    localparam int  PHASES        = 6;
    localparam int  PHASE_RESULTS = 250;
    localparam time RUN_LIMIT     = 10ms;

    typedef enum int {RX_FREE, RX_HALF, RX_SPARSE, RX_EVERY_THIRD} rx_mode_e;

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   due_count;

    int                   hold_requests = 0;
    int                   holds_done    = 0;
    logic                 pace_on       = 1'b0;
    int                   burst_left    = 0;
    int                   block_fill    = 0;
    int                   results_made  = 0;
    int                   cur_near      = int'(RST_NEAR_THRESHOLD);
    int                   cur_off       = int'(RST_SAMPLE_OFFSET);
    int                   prev_sample   = 0;

    m3irs_in_if  smp_ch();
    m3irs_out_if res_ch();

    median3_ir_range_sampler i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_smp      (smp_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    m3irs_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_smp         (smp_ch),
        .i_res         (res_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (due_count)
    );

    always #(HALF_PERIOD) clk = ~clk;

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = CFG_W'(value);
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    task automatic load_settings(input int near, input int far, input int scale,
                                 input int off);
        write_reg(REG_NEAR_THRESHOLD, near);
        write_reg(REG_FAR_DISTANCE, far);
        write_reg(REG_SCALE_NUMERATOR, scale);
        write_reg(REG_SAMPLE_OFFSET, off);
        cur_near = near;
        cur_off  = off;
    endtask

    task automatic random_settings();
        int near;
        int off;
        int scale;
        near = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 600);
        off  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 400);
        case ($urandom_range(0, 3))
            0:       scale = 1048575;
            1:       scale = $urandom_range(0, 4095);
            default: scale = $urandom_range(0, 1048575);
        endcase
        load_settings(near, $urandom_range(0, 65535), scale, off);
    endtask

    // hold valid until the transfer, then idle between bursts
    task automatic send_item(input sampler_req_e req, input logic [SAMPLE_W-1:0] value);
        int gap;
        @(negedge clk);
        smp_ch.valid    = 1'b1;
        smp_ch.req_type = req;
        smp_ch.sample   = value;
        @(posedge clk);
        while (!smp_ch.ready) @(posedge clk);
        if (req == REQ_RELEASE) begin
            block_fill = 0;
        end else begin
            prev_sample = value;
            if (block_fill < BLOCK_LEN) begin
                block_fill++;
                results_made++;
            end
        end
        if (pace_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                         : $urandom_range(0, 15);
                gap = $urandom_range(1, 12);
                @(negedge clk);
                smp_ch.valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        smp_ch.valid = 1'b0;
        while (due_count != 0) @(negedge clk);
        // let a trailing release or ignored sample retire
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 6))
            0, 1: v = $urandom_range(0, 4095);
            2:    v = cur_near + int'($urandom_range(0, 8)) - 4;
            3:    v = cur_off + int'($urandom_range(0, 8)) - 4;
            4:    v = cur_off + int'($urandom_range(1, 64));
            5:    v = ($urandom_range(0, 1) == 1) ? 4095 : 0;
            default: v = prev_sample + int'($urandom_range(0, 16)) - 8;
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[SAMPLE_W-1:0];
    endfunction

    // mostly well-formed blocks closed by a release, some left open or overrun
    task automatic run_random(input int goal);
        int stop_at;
        int len;
        stop_at = results_made + goal;
        while (results_made < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3))
                    send_item(REQ_RELEASE, SAMPLE_W'($urandom_range(0, 4095)));
            end else begin
                case ($urandom_range(0, 3))
                    0:       len = $urandom_range(1, 8);
                    1:       len = $urandom_range(9, BLOCK_LEN - 1);
                    2:       len = BLOCK_LEN;
                    default: len = $urandom_range(BLOCK_LEN + 1, BLOCK_LEN + 6);
                endcase
                repeat (len) send_item(REQ_SAMPLE, pick_sample());
                if ($urandom_range(0, 4) != 0)
                    send_item(REQ_RELEASE, SAMPLE_W'($urandom_range(0, 4095)));
            end
        end
    endtask

    initial begin : receiver
        rx_mode_e mode;
        int       span;
        res_ch.ready = 1'b0;
        forever begin
            if (holds_done < hold_requests) begin
                @(negedge clk);
                res_ch.ready = 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
                holds_done++;
            end
            mode = rx_mode_e'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            for (int n = 0; n < span && holds_done >= hold_requests; n++) begin
                @(negedge clk);
                case (mode)
                    RX_FREE:   res_ch.ready = 1'b1;
                    RX_HALF:   res_ch.ready = ($urandom_range(0, 1) == 1);
                    RX_SPARSE: res_ch.ready = ($urandom_range(0, 3) == 0);
                    default:   res_ch.ready = (n % 3 == 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        smp_ch.valid    = 1'b0;
        smp_ch.req_type = REQ_SAMPLE;
        smp_ch.sample   = '0;
        cfg_we          = 1'b0;
        cfg_idx         = REG_NEAR_THRESHOLD;
        cfg_data        = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: startup history, threshold edge, release mid-block
        send_item(REQ_SAMPLE, 12'd0);
        send_item(REQ_SAMPLE, 12'd4095);
        send_item(REQ_SAMPLE, 12'd4095);
        send_item(REQ_SAMPLE, 12'd0);
        send_item(REQ_RELEASE, 12'd4095);
        send_item(REQ_SAMPLE, 12'd494);
        send_item(REQ_SAMPLE, 12'd493);
        send_item(REQ_SAMPLE, 12'd493);
        send_item(REQ_RELEASE, 12'd0);
        send_item(REQ_RELEASE, 12'd2730);
        send_item(REQ_SAMPLE, 12'd2048);
        wait_idle();

        // widest scale, no offset: quotient saturation
        load_settings(0, 65535, 1048575, 0);
        send_item(REQ_SAMPLE, 12'd1);
        send_item(REQ_SAMPLE, 12'd1);
        send_item(REQ_SAMPLE, 12'd16);
        send_item(REQ_SAMPLE, 12'd16);
        send_item(REQ_SAMPLE, 12'd17);
        send_item(REQ_SAMPLE, 12'd0);
        wait_idle();

        // largest offset: divisor never positive
        load_settings(0, 0, 0, 4095);
        send_item(REQ_SAMPLE, 12'd4095);
        send_item(REQ_SAMPLE, 12'd4095);
        send_item(REQ_SAMPLE, 12'd100);
        wait_idle();

        // largest threshold, unit scale: median equal to threshold divides to zero
        load_settings(4095, 43690, 1, 0);
        send_item(REQ_SAMPLE, 12'd4095);
        send_item(REQ_SAMPLE, 12'd4095);
        send_item(REQ_SAMPLE, 12'd4095);

        pace_on = 1'b1;
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                0:           load_settings(0, $urandom_range(0, 65535), 1048575,
                                           $urandom_range(0, 300));
                PHASES - 1:  load_settings(int'(RST_NEAR_THRESHOLD), int'(RST_FAR_DISTANCE),
                                           int'(RST_SCALE_NUMERATOR),
                                           int'(RST_SAMPLE_OFFSET));
                default:     random_settings();
            endcase
            if (phase == 2) begin
                // consumer holds off while samples keep coming back to back
                hold_requests++;
                pace_on = 1'b0;
                repeat (60) send_item(REQ_SAMPLE, pick_sample());
                pace_on = 1'b1;
            end
            if (phase == 3) begin
                run_random(PHASE_RESULTS / 2);
                wait_idle();
                run_random(PHASE_RESULTS / 2);
            end else begin
                run_random(PHASE_RESULTS);
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("median3_ir_range_sampler verification clean");
        else
            $display("median3_ir_range_sampler verification failed");
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("timeout with %0d results still due", due_count);
        $display("median3_ir_range_sampler verification failed");
        $finish;
    end

endmodule

### filelist.f
src/m3irs_pkg.sv
src/m3irs_in_if.sv
src/m3irs_out_if.sv
src/median3_ir_range_sampler.sv
tb/m3irs_tb_pkg.sv
tb/m3irs_checker.sv
tb/median3_ir_range_sampler_test.sv
